// File: design/dual_stepper_phase_sequencer_assert.svh
// Assertion macros shared by the stepper sequencer modules.
`ifndef DUAL_STEPPER_PHASE_SEQUENCER_ASSERT_SVH
`define DUAL_STEPPER_PHASE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define DSPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define DSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dsps_pkg.sv
// Package: field widths, command codes, reset values and beat types for the sequencer.
`default_nettype none
package dsps_pkg;

    localparam int unsigned OPCODE_W  = 8;
    localparam int unsigned ARG_W     = 16;
    localparam int unsigned COILS_W   = 4;
    localparam int unsigned PERIOD_W  = 8;
    localparam int unsigned SPEED_W   = 8;
    localparam int unsigned PRESCALE_W = 8;
    localparam int unsigned RUN_W     = 16;

    // Command codes
    localparam logic [OPCODE_W-1:0] CMD_FORWARD  = 8'h01;
    localparam logic [OPCODE_W-1:0] CMD_BACKWARD = 8'h02;
    localparam logic [OPCODE_W-1:0] CMD_LEFT     = 8'h03;
    localparam logic [OPCODE_W-1:0] CMD_RIGHT    = 8'h04;
    localparam logic [OPCODE_W-1:0] CMD_STOP     = 8'h05;
    localparam logic [OPCODE_W-1:0] CMD_SPEED    = 8'h06;
    localparam logic [OPCODE_W-1:0] CMD_RUNTIME  = 8'h07;
    localparam logic [OPCODE_W-1:0] CMD_PHASE    = 8'h08;

    // Phase mode selectors in the low byte of arg
    localparam logic [7:0] PHASE_ONE = 8'h01;
    localparam logic [7:0] PHASE_TWO = 8'h02;

    // Action codes
    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_COMMAND = 1'b1;

    // Coil patterns (active low)
    localparam logic [COILS_W-1:0] PAT_RESET    = 4'h3;
    localparam logic [COILS_W-1:0] PAT_ONE      = 4'hE;
    localparam logic [COILS_W-1:0] PAT_TWO      = 4'hC;
    localparam logic [COILS_W-1:0] PAT_RELEASED = 4'hF;

    // Reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd40;
    localparam logic [SPEED_W-1:0]  SPEED_RESET  = 8'd30;

    typedef struct packed {
        logic                action;
        logic [OPCODE_W-1:0] opcode;
        logic [ARG_W-1:0]    arg;
    } item_t;

    typedef struct packed {
        logic [COILS_W-1:0] left_coils;
        logic [COILS_W-1:0] right_coils;
        logic               running;
        logic               timed_run;
    } result_t;

endpackage
`default_nettype wire

// File: design/dsps_engine.sv
// Sequencer state, step period register and the per-beat update logic.
`default_nettype none
`include "dual_stepper_phase_sequencer_assert.svh"
module dsps_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [dsps_pkg::PERIOD_W-1:0] cfg_wr_data,
    input  wire logic                          fire,
    input  wire dsps_pkg::item_t               item,
    output dsps_pkg::result_t                  result
);

    logic [dsps_pkg::PERIOD_W-1:0]   step_period_reg;
    logic [dsps_pkg::COILS_W-1:0]    left_pattern_reg,  left_pattern_next;
    logic [dsps_pkg::COILS_W-1:0]    right_pattern_reg, right_pattern_next;
    logic                            enabled_reg,       enabled_next;
    logic                            left_fwd_reg,      left_fwd_next;
    logic                            right_fwd_reg,     right_fwd_next;
    logic [dsps_pkg::SPEED_W-1:0]    speed_reg,         speed_next;
    logic [dsps_pkg::PRESCALE_W-1:0] prescale_reg,      prescale_next;
    logic [dsps_pkg::RUN_W-1:0]      run_count_reg,     run_count_next;
    logic                            run_active_reg,    run_active_next;

    logic [7:0]                      arg_low;
    logic signed [9:0]               step_limit;
    logic                            step_due;
    logic [dsps_pkg::COILS_W-1:0]    left_stepped, right_stepped;

    assign arg_low = item.arg[7:0];

    // Signed limit: period minus speed, both widened by two bits
    assign step_limit = $signed({2'b00, step_period_reg}) - $signed({2'b00, speed_reg});
    assign step_due   = $signed({2'b00, prescale_reg}) > step_limit;

    // Left forward rotates up, right forward rotates down
    assign left_stepped  = left_fwd_reg ? {left_pattern_reg[2:0], left_pattern_reg[3]}
                                        : {left_pattern_reg[0], left_pattern_reg[3:1]};
    assign right_stepped = right_fwd_reg ? {right_pattern_reg[0], right_pattern_reg[3:1]}
                                         : {right_pattern_reg[2:0], right_pattern_reg[3]};

    // Next state for one beat
    always_comb begin
        left_pattern_next  = left_pattern_reg;
        right_pattern_next = right_pattern_reg;
        enabled_next       = enabled_reg;
        left_fwd_next      = left_fwd_reg;
        right_fwd_next     = right_fwd_reg;
        speed_next         = speed_reg;
        prescale_next      = prescale_reg;
        run_count_next     = run_count_reg;
        run_active_next    = run_active_reg;
        if (item.action == dsps_pkg::ACT_COMMAND) begin
            unique case (item.opcode)
                dsps_pkg::CMD_FORWARD: begin
                    enabled_next = 1'b1; left_fwd_next = 1'b1; right_fwd_next = 1'b1;
                    run_active_next = 1'b0;
                end
                dsps_pkg::CMD_BACKWARD: begin
                    enabled_next = 1'b1; left_fwd_next = 1'b0; right_fwd_next = 1'b0;
                    run_active_next = 1'b0;
                end
                dsps_pkg::CMD_LEFT: begin
                    enabled_next = 1'b1; left_fwd_next = 1'b1; right_fwd_next = 1'b0;
                    run_active_next = 1'b0;
                end
                dsps_pkg::CMD_RIGHT: begin
                    enabled_next = 1'b1; left_fwd_next = 1'b0; right_fwd_next = 1'b1;
                    run_active_next = 1'b0;
                end
                dsps_pkg::CMD_STOP: begin
                    enabled_next    = 1'b0;
                    run_active_next = 1'b0;
                end
                dsps_pkg::CMD_SPEED: begin
                    // times ten as shift-and-add, kept to eight bits
                    speed_next    = {arg_low[4:0], 3'b000} + {arg_low[6:0], 1'b0};
                    prescale_next = '0;
                end
                dsps_pkg::CMD_RUNTIME: begin
                    run_count_next  = item.arg;
                    run_active_next = 1'b1;
                end
                dsps_pkg::CMD_PHASE: begin
                    // Other phase modes leave the patterns alone
                    if (arg_low == dsps_pkg::PHASE_ONE) begin
                        left_pattern_next  = dsps_pkg::PAT_ONE;
                        right_pattern_next = dsps_pkg::PAT_ONE;
                    end else if (arg_low == dsps_pkg::PHASE_TWO) begin
                        left_pattern_next  = dsps_pkg::PAT_TWO;
                        right_pattern_next = dsps_pkg::PAT_TWO;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            // Step when the prescaler passes the limit, else count on
            if (enabled_reg) begin
                if (step_due) begin
                    prescale_next      = '0;
                    left_pattern_next  = left_stepped;
                    right_pattern_next = right_stepped;
                end else begin
                    prescale_next = prescale_reg + 1'b1;
                end
            end
            // Countdown after stepping; expiry stops and releases the coils
            if (run_active_reg) begin
                if (run_count_reg != '0) begin
                    run_count_next = run_count_reg - 1'b1;
                end else begin
                    run_active_next    = 1'b0;
                    enabled_next       = 1'b0;
                    left_pattern_next  = dsps_pkg::PAT_RELEASED;
                    right_pattern_next = dsps_pkg::PAT_RELEASED;
                end
            end
        end
    end

    // Hold the state between beats, advance on fire
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_period_reg   <= dsps_pkg::PERIOD_RESET;
            left_pattern_reg  <= dsps_pkg::PAT_RESET;
            right_pattern_reg <= dsps_pkg::PAT_RESET;
            enabled_reg       <= 1'b0;
            left_fwd_reg      <= 1'b1;
            right_fwd_reg     <= 1'b1;
            speed_reg         <= dsps_pkg::SPEED_RESET;
            prescale_reg      <= '0;
            run_count_reg     <= '0;
            run_active_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                step_period_reg <= cfg_wr_data;
            end
            if (fire) begin
                left_pattern_reg  <= left_pattern_next;
                right_pattern_reg <= right_pattern_next;
                enabled_reg       <= enabled_next;
                left_fwd_reg      <= left_fwd_next;
                right_fwd_reg     <= right_fwd_next;
                speed_reg         <= speed_next;
                prescale_reg      <= prescale_next;
                run_count_reg     <= run_count_next;
                run_active_reg    <= run_active_next;
            end
        end
    end

    // Result shows the state after this beat's update
    assign result.left_coils  = left_pattern_next;
    assign result.right_coils = right_pattern_next;
    assign result.running     = enabled_next;
    assign result.timed_run   = run_active_next;

    `DSPS_ASSERT_NEXT(a_expiry_releases,
        fire && item.action == dsps_pkg::ACT_TICK && run_active_reg && run_count_reg == '0,
        left_pattern_reg == dsps_pkg::PAT_RELEASED && right_pattern_reg == dsps_pkg::PAT_RELEASED
            && !enabled_reg && !run_active_reg,
        "run expiry did not stop and release both motors")
    `DSPS_ASSERT_NEXT(a_state_holds_idle, !fire,
        $stable(left_pattern_reg) && $stable(right_pattern_reg) && $stable(enabled_reg)
            && $stable(run_count_reg),
        "sequencer state moved without a beat")

endmodule
`default_nettype wire

// File: design/dual_stepper_phase_sequencer.sv
// Top level: input register, sequencer engine and result register.
// An accepted beat goes to the input register, then to the result register; m_ready low stalls it.
// Throughput: one beat per cycle while m_ready drains the result register; the input
// and result registers form a two-stage pipeline; the engine state updates once per beat.
// Reset: synchronous on aresetn low; clears both valid flags and puts the
// step period, patterns, directions, speed and counters at their reset values.
`default_nettype none
`include "dual_stepper_phase_sequencer_assert.svh"
module dual_stepper_phase_sequencer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [dsps_pkg::PERIOD_W-1:0] cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_action,
    input  wire logic [dsps_pkg::OPCODE_W-1:0] s_opcode,
    input  wire logic [dsps_pkg::ARG_W-1:0]    s_arg,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [dsps_pkg::COILS_W-1:0]       m_left_coils,
    output logic [dsps_pkg::COILS_W-1:0]       m_right_coils,
    output logic                               m_running,
    output logic                               m_timed_run
);

    logic              in_valid_reg;
    dsps_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    dsps_pkg::result_t out_result_reg;
    dsps_pkg::result_t step_result;
    logic              advance;

    // Move the held beat through when the result register is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{action: s_action, opcode: s_opcode, arg: s_arg};
        end
    end

    dsps_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (advance),
        .item        (in_item_reg),
        .result      (step_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_left_coils  = out_result_reg.left_coils;
    assign m_right_coils = out_result_reg.right_coils;
    assign m_running     = out_result_reg.running;
    assign m_timed_run   = out_result_reg.timed_run;

    `DSPS_ASSERT_NEXT(a_stall_holds_beat, in_valid_reg && out_valid_reg && !m_ready,
        in_valid_reg && $stable(in_item_reg),
        "held beat lost while the result register was stalled")
    `DSPS_ASSERT_NOW(a_result_from_beat, $rose(out_valid_reg), $past(in_valid_reg),
        "result appeared without a beat in the input register")

endmodule
`default_nettype wire
